// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define RBD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition must never be true outside reset.
`define RBD_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define RBD_ASSERT(lbl, clk, rst, prop)
`define RBD_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ----- rtl/core/rbd_pkg.sv -----
package rbd_pkg;

   // Stream format constants
   localparam logic [7:0] MAGIC_BYTE  = 8'h30;
   localparam logic [7:0] RUN_FLAG    = 8'h80;
   localparam logic [6:0] LEN_MASK    = 7'h7F;
   localparam logic [7:0] RUN_MIN     = 8'd3;
   localparam logic [7:0] LIT_MIN     = 8'd1;
   localparam logic [7:0] COUNT_MAX   = 8'd130;
   localparam logic [31:0] CAP_RESET  = 32'hFFFF_FFFF;

   // Decoder phases
   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_EXTSIZE = 3'd1;
   localparam logic [2:0] PH_FLAG    = 3'd2;
   localparam logic [2:0] PH_DATA    = 3'd3;
   localparam logic [2:0] PH_DONE    = 3'd4;

   // Result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_HEADER = 3'd1;
   localparam logic [2:0] ST_OVER_CAP   = 3'd2;
   localparam logic [2:0] ST_OVERRUN    = 3'd3;
   localparam logic [2:0] ST_SHORT      = 3'd4;

   // One result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] out_count;
      logic       out_end;
      logic [2:0] out_status;
   } rsp_type;

endpackage

// ----- rtl/core/rle_block_decoder.sv -----
// Run-length block decoder: takes a compressed stream one byte per transfer.
// Request channel (req_valid/req_stall): one stream byte and a last-byte mark.
// Response channel (rsp_valid/rsp_stall): at most one result per byte, giving
//   a byte value, its repeat count, an end mark and a status code.
// CSR channel (csr_valid/csr_ready): writes the output capacity; csr_ready is
//   always high. Write it only while no stream is in flight.
// Path: a byte accepted into the input register is decoded in a single pass
//   and its result is written to the response register, or to the skid
//   register while the response is held.
// Throughput: one byte per cycle while the skid register is empty, set by the
//   single decode pass from the input register to the response register, which
//   updates all header and block state in the same cycle.
// When the receiver stalls, the response is held and one further result is
//   kept in a skid register; req_stall rises only once that register is full,
//   and comes from flops alone.
// Reset (synchronous, active high): empties all registers, puts the decoder
//   at the magic byte and sets the capacity to all ones.
`include "assert_macros.svh"

module rle_block_decoder (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [7:0]  rsp_out_count,
   output logic        rsp_out_end,
   output logic [2:0]  rsp_out_status,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_out_capacity
);

   // Configuration
   logic [31:0] cap_ff;

   // Input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;

   // Decoder state
   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  hidx_ff, hidx_in;
   logic [31:0] rem_ff, rem_in;
   logic [7:0]  left_ff, left_in;
   logic        run_ff, run_in;

   // Output register and skid
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   rbd_pkg::rsp_type  out_ff, skid_ff, res;
   logic              res_valid;

   logic req_take, rsp_take, s1_fire;

   // Decode temporaries
   logic        fail;
   logic [2:0]  fail_status;
   logic        fin;
   logic        sz_check;
   logic [31:0] sz_val;
   logic [7:0]  cnt;
   logic [7:0]  left_next;
   logic [31:0] rem_next;
   logic [1:0]  hidx_m1;

   assign csr_ready = 1'b1;

   // Handshakes
   assign req_stall = s1_valid_ff & skid_valid_ff;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_take  = out_valid_ff & ~rsp_stall;
   assign s1_fire   = s1_valid_ff & ~skid_valid_ff;

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_ff.out_byte;
   assign rsp_out_count  = out_ff.out_count;
   assign rsp_out_end    = out_ff.out_end;
   assign rsp_out_status = out_ff.out_status;

   // Single-pass decode of the byte in the input register
   always_comb begin
      phase_in    = phase_ff;
      hidx_in     = hidx_ff;
      rem_in      = rem_ff;
      left_in     = left_ff;
      run_in      = run_ff;
      res         = '0;
      res_valid   = 1'b0;
      fail        = 1'b0;
      fail_status = rbd_pkg::ST_OK;
      fin         = 1'b0;
      sz_check    = 1'b0;
      sz_val      = rem_ff;
      hidx_m1     = hidx_ff - 2'd1;
      cnt         = 8'd0;
      left_next   = 8'd0;
      rem_next    = rem_ff;

      unique case (phase_ff)
         rbd_pkg::PH_HEADER: begin
            if (hidx_ff == 2'd0) begin
               if (s1_byte_ff != rbd_pkg::MAGIC_BYTE) begin
                  fail        = 1'b1;
                  fail_status = rbd_pkg::ST_BAD_HEADER;
               end else begin
                  hidx_in = 2'd1;
                  rem_in  = '0;
                  if (s1_last_ff) begin
                     fail        = 1'b1;
                     fail_status = rbd_pkg::ST_BAD_HEADER;
                  end
               end
            end else begin
               rem_in[{hidx_m1, 3'b000} +: 8] = s1_byte_ff;
               if (hidx_ff != 2'd3) begin
                  hidx_in = hidx_ff + 2'd1;
                  if (s1_last_ff) begin
                     fail        = 1'b1;
                     fail_status = rbd_pkg::ST_BAD_HEADER;
                  end
               end else if (rem_in[23:0] == 24'd0) begin
                  // zero short size: extended size follows
                  if (s1_last_ff) begin
                     fail        = 1'b1;
                     fail_status = rbd_pkg::ST_BAD_HEADER;
                  end else begin
                     phase_in = rbd_pkg::PH_EXTSIZE;
                     hidx_in  = 2'd0;
                  end
               end else begin
                  sz_check = 1'b1;
                  sz_val   = {8'd0, rem_in[23:0]};
               end
            end
         end
         rbd_pkg::PH_EXTSIZE: begin
            rem_in[{hidx_ff, 3'b000} +: 8] = s1_byte_ff;
            if (hidx_ff != 2'd3) begin
               hidx_in = hidx_ff + 2'd1;
               if (s1_last_ff) begin
                  fail        = 1'b1;
                  fail_status = rbd_pkg::ST_BAD_HEADER;
               end
            end else begin
               sz_check = 1'b1;
               sz_val   = rem_in;
            end
         end
         rbd_pkg::PH_FLAG: begin
            if ((s1_byte_ff & rbd_pkg::RUN_FLAG) != 8'd0) begin
               cnt = {1'b0, s1_byte_ff[6:0] & rbd_pkg::LEN_MASK} + rbd_pkg::RUN_MIN;
            end else begin
               cnt = {1'b0, s1_byte_ff[6:0] & rbd_pkg::LEN_MASK} + rbd_pkg::LIT_MIN;
            end
            if ({24'd0, cnt} > rem_ff) begin
               fail        = 1'b1;
               fail_status = rbd_pkg::ST_OVERRUN;
            end else begin
               left_in  = cnt;
               run_in   = s1_byte_ff[7];
               phase_in = rbd_pkg::PH_DATA;
               if (s1_last_ff) begin
                  fail        = 1'b1;
                  fail_status = rbd_pkg::ST_SHORT;
               end
            end
         end
         rbd_pkg::PH_DATA: begin
            cnt       = run_ff ? left_ff : 8'd1;
            left_next = run_ff ? 8'd0 : left_ff - 8'd1;
            rem_next  = rem_ff - {24'd0, cnt};
            res_valid = 1'b1;
            res.out_byte   = s1_byte_ff;
            res.out_count  = cnt;
            res.out_status = rbd_pkg::ST_OK;
            if (rem_next == 32'd0) begin
               res.out_end = 1'b1;
               fin         = 1'b1;
            end else if (s1_last_ff) begin
               res.out_end    = 1'b1;
               res.out_status = rbd_pkg::ST_SHORT;
               fin            = 1'b1;
            end else begin
               rem_in  = rem_next;
               left_in = left_next;
               if (left_next == 8'd0) begin
                  phase_in = rbd_pkg::PH_FLAG;
               end
            end
         end
         default: begin
            // done: drop bytes until the stream's last byte
            if (s1_last_ff) begin
               fin = 1'b1;
            end
         end
      endcase

      // declared size is complete
      if (sz_check) begin
         if (sz_val > cap_ff) begin
            fail        = 1'b1;
            fail_status = rbd_pkg::ST_OVER_CAP;
         end else if (sz_val == 32'd0) begin
            fail        = 1'b1;
            fail_status = rbd_pkg::ST_OK;
         end else begin
            rem_in   = sz_val;
            hidx_in  = 2'd0;
            phase_in = rbd_pkg::PH_FLAG;
            if (s1_last_ff) begin
               fail        = 1'b1;
               fail_status = rbd_pkg::ST_SHORT;
            end
         end
      end

      // pure status result
      if (fail) begin
         res_valid      = 1'b1;
         res            = '0;
         res.out_end    = 1'b1;
         res.out_status = fail_status;
         fin            = 1'b1;
      end

      // stream finished: clear and wait for next header or last byte
      if (fin) begin
         hidx_in  = 2'd0;
         rem_in   = '0;
         left_in  = 8'd0;
         run_in   = 1'b0;
         phase_in = s1_last_ff ? rbd_pkg::PH_HEADER : rbd_pkg::PH_DONE;
      end
   end

   // Input register and output queue control
   always_comb begin
      s1_valid_in   = req_take | (s1_valid_ff & ~s1_fire);
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (~out_valid_ff | rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = s1_fire & res_valid;
         end
      end else if (s1_fire & res_valid) begin
         skid_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= rbd_pkg::CAP_RESET;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         phase_ff      <= rbd_pkg::PH_HEADER;
         hidx_ff       <= 2'd0;
         rem_ff        <= '0;
         left_ff       <= 8'd0;
         run_ff        <= 1'b0;
      end else begin
         if (csr_valid & csr_ready) begin
            cap_ff <= csr_out_capacity;
         end
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (s1_fire) begin
            phase_ff <= phase_in;
            hidx_ff  <= hidx_in;
            rem_ff   <= rem_in;
            left_ff  <= left_in;
            run_ff   <= run_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_in_byte;
         s1_last_ff <= req_in_last;
      end
      if (~out_valid_ff | rsp_take) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (s1_fire & res_valid) begin
            out_ff <= res;
         end
      end else if (s1_fire & res_valid) begin
         skid_ff <= res;
      end
   end

   // Checks
   `RBD_NEVER(a_skid_needs_out, clock, reset, skid_valid_ff & ~out_valid_ff)
   `RBD_ASSERT(a_err_ends, clock, reset,
      (out_valid_ff && out_ff.out_status != rbd_pkg::ST_OK) |-> out_ff.out_end)
   `RBD_ASSERT(a_status_only, clock, reset,
      (out_valid_ff && out_ff.out_count == 8'd0) |-> (out_ff.out_end && out_ff.out_byte == 8'd0))
   `RBD_ASSERT(a_count_max, clock, reset,
      out_valid_ff |-> (out_ff.out_count <= rbd_pkg::COUNT_MAX))
   `RBD_ASSERT(a_block_live, clock, reset,
      (phase_ff == rbd_pkg::PH_DATA) |-> (left_ff != 8'd0 && rem_ff != 32'd0))

endmodule

// ----- test/rbd_checker.sv -----
// Watches all three channels of the run-length decoder, predicts each
// result from the accepted stream bytes and compares it with the
// response transfers in order.
module rbd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic [7:0]  rsp_out_count,
   input  logic        rsp_out_end,
   input  logic [2:0]  rsp_out_status,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_out_capacity,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   // Decoder state kept alongside the block
   logic [2:0]        phase;
   logic [2:0]        hdr_idx;
   logic [31:0]       out_left;
   logic [7:0]        blk_left;
   logic              blk_run;
   logic [31:0]       capacity;
   rbd_pkg::rsp_type  expected_q[$];
   int                errs;
   int                seen;

   function automatic rbd_pkg::rsp_type make_result(logic [7:0] b, logic [7:0] n, logic e,
                                                    logic [2:0] st);
      rbd_pkg::rsp_type r;
      r.out_byte   = b;
      r.out_count  = n;
      r.out_end    = e;
      r.out_status = st;
      return r;
   endfunction

   // End of stream: straight back to the magic byte on the last byte,
   // otherwise skip bytes until the last one
   function automatic void close_stream(logic last);
      hdr_idx  = '0;
      out_left = '0;
      blk_left = '0;
      blk_run  = 1'b0;
      phase    = last ? rbd_pkg::PH_HEADER : rbd_pkg::PH_DONE;
   endfunction

   function automatic rbd_pkg::rsp_type abort_stream(logic [2:0] st, logic last);
      close_stream(last);
      return make_result(8'h00, 8'h00, 1'b1, st);
   endfunction

   // Declared size is complete: capacity check, empty output, early end
   function automatic bit size_done(logic last, output rbd_pkg::rsp_type r);
      r = '0;
      if (out_left > capacity) begin
         r = abort_stream(rbd_pkg::ST_OVER_CAP, last);
         return 1'b1;
      end
      if (out_left == 0) begin
         r = abort_stream(rbd_pkg::ST_OK, last);
         return 1'b1;
      end
      phase = rbd_pkg::PH_FLAG;
      if (last) begin
         r = abort_stream(rbd_pkg::ST_SHORT, last);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // One stream byte in, at most one decoded result out
   function automatic bit decode_byte(logic [7:0] b, logic last, output rbd_pkg::rsp_type r);
      bit         hit;
      logic [7:0] n;
      hit = 1'b0;
      r   = '0;
      case (phase)
         rbd_pkg::PH_HEADER: begin
            if (hdr_idx == 3'd0) begin
               if (b != rbd_pkg::MAGIC_BYTE) begin
                  r   = abort_stream(rbd_pkg::ST_BAD_HEADER, last);
                  hit = 1'b1;
               end else begin
                  hdr_idx  = 3'd1;
                  out_left = '0;
                  if (last) begin
                     r   = abort_stream(rbd_pkg::ST_BAD_HEADER, last);
                     hit = 1'b1;
                  end
               end
            end else begin
               // 24-bit little-endian size
               out_left = out_left | ({24'd0, b} << (8 * (hdr_idx - 3'd1)));
               hdr_idx  = hdr_idx + 3'd1;
               if (hdr_idx < 3'd4) begin
                  if (last) begin
                     r   = abort_stream(rbd_pkg::ST_BAD_HEADER, last);
                     hit = 1'b1;
                  end
               end else begin
                  out_left = out_left & 32'h00FF_FFFF;
                  if (out_left == 0) begin
                     // zero short size: an extended size must follow
                     if (last) begin
                        r   = abort_stream(rbd_pkg::ST_BAD_HEADER, last);
                        hit = 1'b1;
                     end else begin
                        phase   = rbd_pkg::PH_EXTSIZE;
                        hdr_idx = 3'd0;
                     end
                  end else begin
                     hit = size_done(last, r);
                  end
               end
            end
         end
         rbd_pkg::PH_EXTSIZE: begin
            out_left = out_left | ({24'd0, b} << (8 * hdr_idx));
            hdr_idx  = hdr_idx + 3'd1;
            if (hdr_idx < 3'd4) begin
               if (last) begin
                  r   = abort_stream(rbd_pkg::ST_BAD_HEADER, last);
                  hit = 1'b1;
               end
            end else begin
               hit = size_done(last, r);
            end
         end
         rbd_pkg::PH_FLAG: begin
            blk_run = (b & rbd_pkg::RUN_FLAG) != 0;
            n = {1'b0, b[6:0] & rbd_pkg::LEN_MASK} +
                (blk_run ? rbd_pkg::RUN_MIN : rbd_pkg::LIT_MIN);
            if ({24'd0, n} > out_left) begin
               r   = abort_stream(rbd_pkg::ST_OVERRUN, last);
               hit = 1'b1;
            end else begin
               blk_left = n;
               phase    = rbd_pkg::PH_DATA;
               if (last) begin
                  r   = abort_stream(rbd_pkg::ST_SHORT, last);
                  hit = 1'b1;
               end
            end
         end
         rbd_pkg::PH_DATA: begin
            // a run is emitted whole, a literal byte by byte
            n        = blk_run ? blk_left : rbd_pkg::LIT_MIN;
            blk_left = blk_run ? 8'd0 : blk_left - 8'd1;
            out_left = out_left - {24'd0, n};
            hit      = 1'b1;
            if (out_left == 0) begin
               close_stream(last);
               r = make_result(b, n, 1'b1, rbd_pkg::ST_OK);
            end else begin
               if (blk_left == 0) phase = rbd_pkg::PH_FLAG;
               if (last) begin
                  close_stream(last);
                  r = make_result(b, n, 1'b1, rbd_pkg::ST_SHORT);
               end else begin
                  r = make_result(b, n, 1'b0, rbd_pkg::ST_OK);
               end
            end
         end
         default: begin
            if (last) close_stream(1'b1);
         end
      endcase
      return hit;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         errs++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Predict on request transfers, compare on response transfers
   always @(posedge clock) begin : watch
      rbd_pkg::rsp_type want;
      rbd_pkg::rsp_type got;
      bit               hit;
      if (reset) begin
         phase    = rbd_pkg::PH_HEADER;
         hdr_idx  = '0;
         out_left = '0;
         blk_left = '0;
         blk_run  = 1'b0;
         capacity = rbd_pkg::CAP_RESET;
         expected_q.delete();
         errs     = 0;
         seen     = 0;
      end else begin
         if (csr_valid && csr_ready) capacity = csr_out_capacity;
         if (req_valid && !req_stall) begin
            hit = decode_byte(req_in_byte, req_in_last, want);
            if (hit) expected_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_byte, rsp_out_count, rsp_out_end, rsp_out_status};
            if (expected_q.size() == 0) begin
               errs++;
               $display("%0t: result with none expected: byte %0d count %0d end %0d status %0d",
                        $time, got.out_byte, got.out_count, got.out_end, got.out_status);
            end else begin
               want = expected_q.pop_front();
               seen++;
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("out_count", want.out_count, got.out_count);
               check_field("out_end", {7'd0, want.out_end}, {7'd0, got.out_end});
               check_field("out_status", {5'd0, want.out_status}, {5'd0, got.out_status});
            end
         end
      end
      fail_count <= errs;
      pending    <= expected_q.size();
      checked    <= seen;
   end

endmodule

// ----- test/tb_rle_block_decoder.sv -----
module tb_rle_block_decoder;

   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          PHASE_ITEMS  = 250;
   localparam logic [31:0] SIZE24_MAX   = 32'h00FF_FFFF;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_in_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic [7:0]  rsp_out_count;
   logic        rsp_out_end;
   logic [2:0]  rsp_out_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_out_capacity;
   int          fail_count;
   int          pending;
   int          checked;

   logic [7:0]  stream_q[$];
   logic [31:0] cap_plan [0:5];
   logic [31:0] cur_cap;
   int          junk_n;
   int          phase_items;
   int          streams_sent;
   int          bytes_sent;
   int          cap_writes;
   int          cycle_count = 0;
   int          rsp_hold;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   rle_block_decoder dut (.*);
   rbd_checker       chk (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Wait cycles per item; calm stretches have none
   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   // Receiver stall after each response transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  = 0;
      end else if (rsp_stall) begin
         rsp_hold--;
         if (rsp_hold <= 0) rsp_stall <= 1'b0;
      end else if (rsp_valid) begin
         rsp_hold = draw_wait(rsp_calm);
         if (rsp_hold != 0) rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("tb_rle_block_decoder: FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_q.size(); i++)
         send_byte(stream_q[i], i == stream_q.size() - 1);
      streams_sent++;
      bytes_sent  += stream_q.size();
      phase_items += stream_q.size() - junk_n;
   endtask

   // Wait until every expected result has come and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [31:0] v);
      csr_valid        <= 1'b1;
      csr_out_capacity <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_cap = v;
      cap_writes++;
   endtask

   // Magic byte and size; the extended form when asked or when required
   task automatic add_header(input logic [31:0] out_size, input bit ext);
      stream_q.push_back(rbd_pkg::MAGIC_BYTE);
      if (ext || out_size == 0 || out_size > SIZE24_MAX) begin
         repeat (3) stream_q.push_back(8'h00);
         for (int k = 0; k < 4; k++) stream_q.push_back(out_size[8*k +: 8]);
      end else begin
         for (int k = 0; k < 3; k++) stream_q.push_back(out_size[8*k +: 8]);
      end
   endtask

   // Literal and run blocks up to the declared size; with overrun set, the
   // first block once under 128 bytes remain is too long
   task automatic add_body(input logic [31:0] out_size, input bit overrun, input int max_len);
      logic [31:0] left;
      logic [7:0]  flag;
      int          n;
      int          top;
      left = out_size;
      while (left != 0 && stream_q.size() < max_len) begin
         if (overrun && left < 128) begin
            if ($urandom_range(0, 1)) begin
               n    = $urandom_range((left < 2) ? 3 : left + 1, 130);
               flag = 8'(n - 3);
               stream_q.push_back(flag | rbd_pkg::RUN_FLAG);
            end else begin
               n    = $urandom_range(left + 1, 128);
               flag = 8'(n - 1);
               stream_q.push_back(flag);
            end
            return;
         end
         if (left >= 3 && $urandom_range(0, 2) == 0) begin
            top = (left < 130) ? left : 130;
            if ($urandom_range(0, 3) != 0 && top > 12) top = 12;
            n    = ($urandom_range(0, 3) == 0) ? top : $urandom_range(3, top);
            flag = 8'(n - 3);
            stream_q.push_back(flag | rbd_pkg::RUN_FLAG);
            stream_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            top = (left < 128) ? left : 128;
            if ($urandom_range(0, 3) != 0 && top > 8) top = 8;
            n    = ($urandom_range(0, 3) == 0) ? top : $urandom_range(1, top);
            flag = 8'(n - 1);
            stream_q.push_back(flag);
            repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
         end
         left = left - n;
      end
   endtask

   task automatic add_junk();
      junk_n = $urandom_range(0, 3);
      repeat (junk_n) stream_q.push_back(8'($urandom_range(0, 255)));
   endtask

   // One random stream: mostly well formed, the rest broken or noise
   task automatic random_stream();
      int          kind;
      int          n;
      int          cut;
      logic [31:0] lim;
      logic [31:0] out_size;
      kind = $urandom_range(0, 99);
      stream_q.delete();
      junk_n = 0;
      lim = (cur_cap < 24) ? cur_cap : 24;
      if ($urandom_range(0, 11) == 0) lim = (cur_cap < 400) ? cur_cap : 400;
      out_size = (lim == 0) ? 32'd0 : $urandom_range(1, lim);
      if (kind < 7) begin
         // noise, usually a bad magic byte
         n = $urandom_range(1, 6);
         repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 12 || out_size == 0) begin
         add_header(32'd0, 1'b1);
         add_junk();
      end else if (kind < 18 && cur_cap != rbd_pkg::CAP_RESET) begin
         out_size = $urandom_range(0, 1) ? cur_cap + 1 :
                    $urandom_range(cur_cap + 1, rbd_pkg::CAP_RESET);
         add_header(out_size, $urandom_range(0, 3) == 0);
         add_junk();
      end else if (kind < 24) begin
         // declared size up to the full capacity, input usually ends long before the output is done
         out_size = $urandom_range(1, cur_cap);
         add_header(out_size, $urandom_range(0, 1));
         add_body(out_size, 1'b0, stream_q.size() + $urandom_range(1, 40));
      end else if (kind < 36) begin
         add_header(out_size, $urandom_range(0, 4) == 0);
         add_body(out_size, 1'b1, 100000);
         add_junk();
      end else begin
         add_header(out_size, $urandom_range(0, 4) == 0);
         add_body(out_size, 1'b0, 100000);
         if (kind < 52) begin
            cut = $urandom_range(1, stream_q.size());
            while (stream_q.size() > cut) void'(stream_q.pop_back());
         end else if ($urandom_range(0, 3) == 0) begin
            add_junk();
         end
      end
      send_stream();
   endtask

   initial begin : stimulus
      int waited;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_byte      = 8'h00;
      req_in_last      = 1'b0;
      csr_valid        = 1'b0;
      csr_out_capacity = 32'h0;
      streams_sent     = 0;
      bytes_sent       = 0;
      cap_writes       = 0;
      cap_plan[0] = rbd_pkg::CAP_RESET;
      cap_plan[1] = 32'h0;
      cap_plan[2] = 32'h1;
      cap_plan[3] = {24'd0, rbd_pkg::COUNT_MAX};
      cap_plan[4] = $urandom_range(131, SIZE24_MAX);
      cap_plan[5] = 32'h0100_0000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) settle();
         write_capacity(cap_plan[ph]);
         phase_items = 0;
         if (ph == 0) begin
            junk_n = 0;
            // wrong magic byte
            stream_q = '{8'h31};
            send_stream();
            // zero short size with no room for the extended size
            stream_q = '{rbd_pkg::MAGIC_BYTE, 8'h00, 8'h00, 8'h00};
            send_stream();
            // extended size of zero: empty output
            stream_q = '{rbd_pkg::MAGIC_BYTE, 8'h00, 8'h00, 8'h00,
                         8'h00, 8'h00, 8'h00, 8'h00};
            send_stream();
            // longest run, then a byte after the end that must be ignored
            junk_n = 1;
            stream_q = '{rbd_pkg::MAGIC_BYTE, rbd_pkg::COUNT_MAX, 8'h00, 8'h00,
                         8'hFF, 8'hA5, 8'h5A};
            send_stream();
            junk_n = 0;
            // run of three against two bytes left
            stream_q = '{rbd_pkg::MAGIC_BYTE, 8'd2, 8'h00, 8'h00, rbd_pkg::RUN_FLAG};
            send_stream();
            // input ends on a data byte while output is still due
            stream_q = '{rbd_pkg::MAGIC_BYTE, 8'd3, 8'h00, 8'h00, 8'h00, 8'hC3};
            send_stream();
         end
         while (phase_items < PHASE_ITEMS) random_stream();
      end

      // drain, then give the verdict
      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      $display("covered %0d streams, %0d bytes, under %0d capacity settings",
               streams_sent, bytes_sent, cap_writes);
      $display("%0d results compared, %0d mismatches, %0d never arrived",
               checked, fail_count, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_rle_block_decoder: PASS");
      end else begin
         $display("tb_rle_block_decoder: FAIL");
      end
      $finish;
   end

endmodule
